[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file ksc_assert.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/ksc_pkg.sv]
// ----------------------------------------------------------------------------
// ksc_pkg
// Widths, constants and register codes of the knee soft clipper.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int FRAC_W    = 20;
    localparam int SAMPLE_W  = 24;
    localparam int LEVEL_W   = 23;
    localparam int ASYM_W    = 21;
    localparam int CFG_IDX_W = 2;

    localparam int QB     = 23;
    localparam int DIV_W  = 38;
    localparam int S_W    = 23;
    localparam int S2_W   = 25;
    localparam int NUM_W  = 58;
    localparam int DEN_W  = 38;
    localparam int T_W    = 20;
    localparam int W_W    = 21;

    localparam int TANH_LAT = 6;
    localparam int IDX_B    = QB + 1;
    localparam int IDX_DB   = IDX_B + TANH_LAT;
    localparam int IDX_C1   = IDX_DB + QB + 1;
    localparam int IDX_C2   = IDX_C1 + 1;
    localparam int IDX_M1   = IDX_C2 + 1;
    localparam int IDX_M2   = IDX_M1 + 1;
    localparam int IDX_G1   = IDX_M2 + 1;
    localparam int IDX_OUT  = IDX_G1 + 1;
    localparam int PIPE_LEN = IDX_OUT + 1;

    localparam logic [W_W-1:0]     ONE_Q20    = 21'h100000;
    localparam logic [S_W-1:0]     TANH_LIMIT = 23'd4718592;
    localparam logic [21:0]        SMOOTH_K   = 22'd3145728;

    localparam logic [35:0]        PADE_N0 = 36'd10395 << 20;
    localparam logic [30:0]        PADE_N1 = 31'd1260 << 20;
    localparam logic [30:0]        PADE_N2 = 31'd21;
    localparam logic [DEN_W-1:0]   PADE_D0 = 38'd10395 << 20;
    localparam logic [33:0]        PADE_D1 = 34'd4725 << 20;
    localparam logic [27:0]        PADE_D2 = 28'd210 << 20;

    localparam logic [LEVEL_W-1:0] THR_RESET  = 23'd1048576;
    localparam logic [LEVEL_W-1:0] KNEE_RESET = 23'd104858;
    localparam logic [ASYM_W-1:0]  ASYM_RESET = 21'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_KNEE      = 2'd1,
        REG_ASYM      = 2'd2
    } cfg_reg_t;

endpackage

[rtl/core/ksc_div.sv]
// ----------------------------------------------------------------------------
// ksc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ksc_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ksc_pkg::DIV_W-1:0]   rem_in,
    input  logic [ksc_pkg::QB-1:0]      low_in,
    input  logic [ksc_pkg::DIV_W-1:0]   divisor,
    output logic [ksc_pkg::QB-1:0]      quotient
);

    logic [ksc_pkg::DIV_W-1:0] rem_reg  [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W-1:0] rem_next [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W-1:0] dvs_reg  [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W-1:0] dvs_next [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    low_reg  [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    low_next [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    quo_reg  [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    quo_next [ksc_pkg::QB];

    logic [ksc_pkg::DIV_W-1:0] src_rem [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W-1:0] src_dvs [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    src_low [ksc_pkg::QB];
    logic [ksc_pkg::QB-1:0]    src_quo [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W:0]   shifted [ksc_pkg::QB];
    logic [ksc_pkg::DIV_W:0]   trial   [ksc_pkg::QB];

    assign src_rem[0] = rem_in;
    assign src_dvs[0] = divisor;
    assign src_low[0] = low_in;
    assign src_quo[0] = '0;

    for (genvar i = 1; i < ksc_pkg::QB; i++)
    begin : g_src
        assign src_rem[i] = rem_reg[i-1];
        assign src_dvs[i] = dvs_reg[i-1];
        assign src_low[i] = low_reg[i-1];
        assign src_quo[i] = quo_reg[i-1];
    end

    always_comb
    begin
        for (int i = 0; i < ksc_pkg::QB; i++)
        begin
            shifted[i]  = {src_rem[i], src_low[i][ksc_pkg::QB-1]};
            trial[i]    = shifted[i] - {1'b0, src_dvs[i]};
            dvs_next[i] = src_dvs[i];
            low_next[i] = {src_low[i][ksc_pkg::QB-2:0], 1'b0};
            if (!trial[i][ksc_pkg::DIV_W])
            begin
                rem_next[i] = trial[i][ksc_pkg::DIV_W-1:0];
                quo_next[i] = {src_quo[i][ksc_pkg::QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[i][ksc_pkg::DIV_W-1:0];
                quo_next[i] = {src_quo[i][ksc_pkg::QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg[ksc_pkg::QB-1];

endmodule

[rtl/core/ksc_tanh.sv]
// ----------------------------------------------------------------------------
// ksc_tanh
// Six-stage evaluation of the numerator and denominator of the Pade tanh.
// ----------------------------------------------------------------------------
module ksc_tanh (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ksc_pkg::S_W-1:0]     s_in,
    output logic [ksc_pkg::NUM_W-1:0]   num,
    output logic [ksc_pkg::DEN_W-1:0]   den
);

    logic [ksc_pkg::S_W-1:0]   s1_reg, s2c_reg, s3_reg, s4_reg;
    logic [ksc_pkg::S2_W-1:0]  sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic [30:0]               bn_reg, bn_next;
    logic [27:0]               bd_reg, bd_next;
    logic [35:0]               pn_reg;
    logic [32:0]               pd_reg;
    logic [35:0]               an_reg, an_next;
    logic [33:0]               cd_reg, cd_next;
    logic [40:0]               nlo_reg, nhi_reg;
    logic [37:0]               qd_reg;
    logic [ksc_pkg::NUM_W-1:0] num_reg, num_next;
    logic [ksc_pkg::DEN_W-1:0] den_reg, den_next;

    logic [45:0] sq_prod;
    logic [55:0] pn_prod;
    logic [52:0] pd_prod;
    logic [58:0] qd_prod;
    logic [40:0] nlo_next, nhi_next;

    assign sq_prod  = s_in * s_in;
    assign bn_next  = ksc_pkg::PADE_N1 + 31'(sq1_reg) * ksc_pkg::PADE_N2;
    assign bd_next  = ksc_pkg::PADE_D2 + 28'(sq1_reg);
    assign pn_prod  = sq2_reg * bn_reg;
    assign pd_prod  = sq2_reg * bd_reg;
    assign an_next  = ksc_pkg::PADE_N0 + pn_reg;
    assign cd_next  = ksc_pkg::PADE_D1 + 34'(pd_reg);
    assign nlo_next = s4_reg * an_reg[17:0];
    assign nhi_next = s4_reg * an_reg[35:18];
    assign qd_prod  = sq4_reg * cd_reg;
    assign num_next = ksc_pkg::NUM_W'(nlo_reg) + ksc_pkg::NUM_W'({nhi_reg, 18'd0});
    assign den_next = ksc_pkg::PADE_D0 + qd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s_in;
            sq1_reg <= sq_prod[44:20];
            s2c_reg <= s1_reg;
            sq2_reg <= sq1_reg;
            bn_reg  <= bn_next;
            bd_reg  <= bd_next;
            s3_reg  <= s2c_reg;
            sq3_reg <= sq2_reg;
            pn_reg  <= pn_prod[55:20];
            pd_reg  <= pd_prod[52:20];
            s4_reg  <= s3_reg;
            sq4_reg <= sq3_reg;
            an_reg  <= an_next;
            cd_reg  <= cd_next;
            nlo_reg <= nlo_next;
            nhi_reg <= nhi_next;
            qd_reg  <= qd_prod[57:20];
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign num = num_reg;
    assign den = den_reg;

endmodule

[rtl/core/knee_soft_clipper.sv]
// ----------------------------------------------------------------------------
// knee_soft_clipper: soft clipper with a smoothstep knee and Pade tanh.
// Throughput is one beat per cycle while out_ready does not stall the pipeline,
// which holds the three 23-stage divider pipelines.
// Reset restores the register defaults and empties the pipeline at once.
// ----------------------------------------------------------------------------
module knee_soft_clipper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ksc_pkg::LEVEL_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [ksc_pkg::SAMPLE_W-1:0] sample_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ksc_pkg::SAMPLE_W-1:0] sample_out
);

    typedef struct packed {
        logic                            pos;
        logic                            byp;
        logic [ksc_pkg::SAMPLE_W-1:0]    ybyp;
        logic [ksc_pkg::SAMPLE_W-1:0]    ax;
        logic                            in_knee;
        logic                            usign;
        logic                            sat;
        logic [ksc_pkg::T_W-1:0]         t;
        logic [ksc_pkg::W_W-1:0]         w;
    } side_t;

    logic                           adv;
    logic [ksc_pkg::LEVEL_W-1:0]    thr_reg, knee_reg;
    logic [ksc_pkg::ASYM_W-1:0]     asym_reg, asym_c;
    logic [ksc_pkg::PIPE_LEN-1:0]   valid_reg, valid_next;
    side_t                          side_reg  [ksc_pkg::IDX_G1+1];
    side_t                          side_next [ksc_pkg::IDX_G1+1];
    side_t                          side_a;

    logic signed [24:0]             x_w, thr_w, start_w, yh_w, du_w;
    logic signed [25:0]             dt_w;
    logic [ksc_pkg::SAMPLE_W-1:0]   ax_a, upper_a, dmag_a;
    logic                           hard_a, pass_a, in_knee_a, usat_a;

    logic [ksc_pkg::DIV_W-1:0]      divt_rem_reg, divt_rem_next, divt_dvs_reg, divt_dvs_next;
    logic [ksc_pkg::DIV_W-1:0]      divu_rem_reg, divu_rem_next, divu_dvs_reg, divu_dvs_next;
    logic [ksc_pkg::QB-1:0]         qt, qu, qd;

    logic                           sat_b;
    logic [ksc_pkg::S_W-1:0]        s_reg, s_next;
    logic [39:0]                    tt_prod;
    logic [ksc_pkg::T_W-1:0]        tt_reg;
    logic [21:0]                    smooth_f;
    logic [41:0]                    w_prod;
    logic [ksc_pkg::W_W-1:0]        w_b2;

    logic [ksc_pkg::NUM_W-1:0]      num;
    logic [ksc_pkg::DEN_W-1:0]      den;

    logic [ksc_pkg::W_W-1:0]        r_c1, w_m;
    logic [43:0]                    kp_reg, kp_next;
    logic signed [25:0]             c_reg, c_next;
    logic [44:0]                    pa_reg, pa_next;
    logic signed [47:0]             pc_reg, pc_next;
    logic [41:0]                    pg_reg, pg_next;
    logic signed [48:0]             sum_m;
    logic [48:0]                    smag;
    logic signed [26:0]             m_reg, m_next;
    logic [ksc_pkg::W_W-1:0]        g_reg, g_next;
    logic signed [48:0]             py_reg, py_next;
    logic [48:0]                    pmag;
    logic [28:0]                    yq;
    logic                           negy;
    logic [ksc_pkg::SAMPLE_W-1:0]   ysat, y_reg, y_next;

    assign adv       = !valid_reg[ksc_pkg::IDX_OUT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[ksc_pkg::IDX_OUT];
    assign sample_out = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= ksc_pkg::THR_RESET;
            knee_reg <= ksc_pkg::KNEE_RESET;
            asym_reg <= ksc_pkg::ASYM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ksc_pkg::REG_THRESHOLD: thr_reg  <= cfg_data;
                ksc_pkg::REG_KNEE:      knee_reg <= cfg_data;
                ksc_pkg::REG_ASYM:      asym_reg <= cfg_data[ksc_pkg::ASYM_W-1:0];
                default: ;
            endcase
        end
    end

    assign asym_c = (asym_reg > ksc_pkg::ONE_Q20) ? ksc_pkg::ONE_Q20 : asym_reg;

    // Front stage: magnitude, bypass decisions and divider operands.
    always_comb
    begin
        x_w       = {sample_in[ksc_pkg::SAMPLE_W-1], sample_in};
        thr_w     = {2'b00, thr_reg};
        start_w   = thr_w - {2'b00, knee_reg};
        ax_a      = sample_in[ksc_pkg::SAMPLE_W-1] ? 24'(-sample_in) : sample_in;
        hard_a    = (knee_reg == '0);
        if (x_w > thr_w)
            yh_w = thr_w;
        else if (x_w < -thr_w)
            yh_w = -thr_w;
        else
            yh_w = x_w;
        pass_a    = $signed({1'b0, ax_a}) < start_w;
        upper_a   = {1'b0, thr_reg} + {1'b0, knee_reg};
        in_knee_a = ax_a < upper_a;
        dt_w      = $signed({2'b00, ax_a}) - $signed({start_w[24], start_w});
        du_w      = $signed({1'b0, ax_a}) - thr_w;
        dmag_a    = du_w[24] ? 24'(-du_w) : du_w[23:0];
        usat_a    = {2'b00, dmag_a} >= {knee_reg, 3'b000};

        side_a.pos     = !sample_in[ksc_pkg::SAMPLE_W-1] && (sample_in != '0);
        side_a.byp     = hard_a || pass_a;
        side_a.ybyp    = hard_a ? yh_w[23:0] : sample_in;
        side_a.ax      = ax_a;
        side_a.in_knee = in_knee_a;
        side_a.usign   = du_w[24];
        side_a.sat     = usat_a;
        side_a.t       = '0;
        side_a.w       = '0;

        divt_rem_next = (in_knee_a && !side_a.byp) ? ksc_pkg::DIV_W'(dt_w[23:0]) : '0;
        divt_dvs_next = ksc_pkg::DIV_W'({knee_reg, 1'b0});
        divu_rem_next = (usat_a || side_a.byp) ? '0 : ksc_pkg::DIV_W'(dmag_a);
        divu_dvs_next = ksc_pkg::DIV_W'({knee_reg, 3'b000});
    end

    ksc_div u_div_t (
        .clk      (clk),
        .en       (adv),
        .rem_in   (divt_rem_reg),
        .low_in   ({ksc_pkg::QB{1'b0}}),
        .divisor  (divt_dvs_reg),
        .quotient (qt)
    );

    ksc_div u_div_u (
        .clk      (clk),
        .en       (adv),
        .rem_in   (divu_rem_reg),
        .low_in   ({ksc_pkg::QB{1'b0}}),
        .divisor  (divu_dvs_reg),
        .quotient (qu)
    );

    assign sat_b    = side_reg[ksc_pkg::IDX_B-1].sat || (qu >= ksc_pkg::TANH_LIMIT);
    assign s_next   = sat_b ? '0 : qu;
    assign tt_prod  = side_reg[ksc_pkg::IDX_B].t * side_reg[ksc_pkg::IDX_B].t;
    assign smooth_f = ksc_pkg::SMOOTH_K - {1'b0, side_reg[ksc_pkg::IDX_B+1].t, 1'b0};
    assign w_prod   = tt_reg * smooth_f;
    assign w_b2     = side_reg[ksc_pkg::IDX_B+1].in_knee ? w_prod[40:20] : ksc_pkg::ONE_Q20;

    ksc_tanh u_tanh (
        .clk  (clk),
        .en   (adv),
        .s_in (s_reg),
        .num  (num),
        .den  (den)
    );

    ksc_div u_div_q (
        .clk      (clk),
        .en       (adv),
        .rem_in   (ksc_pkg::DIV_W'(num[ksc_pkg::NUM_W-1:ksc_pkg::QB])),
        .low_in   (num[ksc_pkg::QB-1:0]),
        .divisor  (den),
        .quotient (qd)
    );

    // Back end: knee level, blend, negative gain and saturation.
    always_comb
    begin
        r_c1    = side_reg[ksc_pkg::IDX_C1-1].sat ? ksc_pkg::ONE_Q20 : qd[20:0];
        kp_next = knee_reg * r_c1;
        if (side_reg[ksc_pkg::IDX_C2-1].usign)
            c_next = $signed({3'b000, thr_reg}) - $signed({2'b00, kp_reg[43:20]});
        else
            c_next = $signed({3'b000, thr_reg}) + $signed({2'b00, kp_reg[43:20]});

        w_m     = side_reg[ksc_pkg::IDX_M1-1].w;
        pa_next = side_reg[ksc_pkg::IDX_M1-1].ax * (ksc_pkg::ONE_Q20 - w_m);
        pc_next = c_reg * $signed({1'b0, w_m});
        pg_next = asym_c * w_m;

        sum_m   = $signed({4'b0000, pa_reg}) + $signed({pc_reg[47], pc_reg});
        smag    = sum_m[48] ? 49'(-sum_m) : sum_m;
        if (sum_m[48])
            m_next = -$signed({1'b0, smag[45:20]});
        else
            m_next = $signed({1'b0, smag[45:20]});
        g_next  = side_reg[ksc_pkg::IDX_M1].pos ? ksc_pkg::ONE_Q20
                                                : ksc_pkg::ONE_Q20 - pg_reg[40:20];

        py_next = m_reg * $signed({1'b0, g_reg});

        pmag    = py_reg[48] ? 49'(-py_reg) : py_reg;
        yq      = pmag[48:20];
        negy    = py_reg[48] ^ !side_reg[ksc_pkg::IDX_G1].pos;
        if (!negy && (yq > 29'd8388607))
            ysat = 24'h7FFFFF;
        else if (negy && (yq > 29'd8388608))
            ysat = 24'h800000;
        else if (negy)
            ysat = 24'(-yq);
        else
            ysat = yq[23:0];
        y_next  = side_reg[ksc_pkg::IDX_G1].byp ? side_reg[ksc_pkg::IDX_G1].ybyp : ysat;
    end

    always_comb
    begin
        side_next[0] = side_a;
        for (int k = 1; k <= ksc_pkg::IDX_G1; k++)
            side_next[k] = side_reg[k-1];
        side_next[ksc_pkg::IDX_B].sat = sat_b;
        side_next[ksc_pkg::IDX_B].t   = qt[ksc_pkg::QB-1:3];
        side_next[ksc_pkg::IDX_B+2].w = w_b2;
    end

    assign valid_next = {valid_reg[ksc_pkg::PIPE_LEN-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg     <= side_next;
            divt_rem_reg <= divt_rem_next;
            divt_dvs_reg <= divt_dvs_next;
            divu_rem_reg <= divu_rem_next;
            divu_dvs_reg <= divu_dvs_next;
            s_reg        <= s_next;
            tt_reg       <= tt_prod[39:20];
            kp_reg       <= kp_next;
            c_reg        <= c_next;
            pa_reg       <= pa_next;
            pc_reg       <= pc_next;
            pg_reg       <= pg_next;
            m_reg        <= m_next;
            g_reg        <= g_next;
            py_reg       <= py_next;
            y_reg        <= y_next;
        end
    end

endmodule

[rtl/core/ksc_assert.sv]
// ----------------------------------------------------------------------------
// ksc_assert
// Port-level checks of the clipper's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksc_assert (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [ksc_pkg::SAMPLE_W-1:0] sample_out
);

    `ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
    `ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
    `ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(sample_out))

endmodule

bind knee_soft_clipper ksc_assert u_ksc_assert (.*);

[tb/tb_knee_soft_clipper.sv]
// ----------------------------------------------------------------------------
// Knee soft clipper testbench
// Streams signed Q4.20 samples through the clipper under several register
// settings, including hard clipping, extreme levels and a threshold below the
// knee. Each output beat is compared with a built-in fixed-point predictor.
// Both handshake sides idle at random, the output is held off for a long
// stretch once, and the input pauses until the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class clip_scoreboard;
    longint unsigned thr;
    longint unsigned knee;
    longint unsigned asym;
    logic signed [23:0] pending[$];
    int errors;

    function new();
        thr = 1048576;
        knee = 104858;
        asym = 0;
        errors = 0;
    endfunction

    function void set_reg(ksc_pkg::cfg_reg_t idx, logic [22:0] value);
        case (idx)
            ksc_pkg::REG_THRESHOLD: thr = value;
            ksc_pkg::REG_KNEE:      knee = value;
            ksc_pkg::REG_ASYM:      asym = value[20:0];
            default: ;
        endcase
    endfunction

    function longint rational_tanh(longint u);
        longint s, s2, num, den, r;
        s = (u < 0) ? -u : u;
        if (s >= 4718592)
            return (u < 0) ? -1048576 : 1048576;
        s2 = (s * s) / 1048576;
        num = s * (64'sd10395 * 1048576 + (s2 * (64'sd1260 * 1048576 + 21 * s2)) / 1048576);
        den = 64'sd10395 * 1048576
              + (s2 * (64'sd4725 * 1048576
                 + (s2 * (64'sd210 * 1048576 + s2)) / 1048576)) / 1048576;
        r = num / den;
        return (u < 0) ? -r : r;
    endfunction

    function logic signed [23:0] clip_sample(logic signed [23:0] xin);
        longint x, t, k, a, ax, knee_start, w, u, c, m, g, y, tt;
        x = xin;
        t = thr;
        k = knee;
        a = (asym > 1048576) ? 1048576 : asym;
        if (k == 0)
            return 24'((x > t) ? t : ((x < -t) ? -t : x));
        ax = (x < 0) ? -x : x;
        knee_start = t - k;
        if (ax < knee_start)
            return xin;
        w = 1048576;
        if (ax < t + k) begin
            tt = ((ax - knee_start) * 1048576) / (2 * k);
            w = (((tt * tt) / 1048576) * (3 * 1048576 - 2 * tt)) / 1048576;
        end
        u = ((ax - t) * 1048576) / k;
        c = t + (k * rational_tanh(u)) / 1048576;
        m = (ax * (1048576 - w) + c * w) / 1048576;
        g = (x > 0) ? 1048576 : 1048576 - (a * w) / 1048576;
        y = (m * g) / 1048576;
        if (!(x > 0))
            y = -y;
        if (y > 8388607)
            y = 8388607;
        if (y < -8388608)
            y = -8388608;
        return 24'(y);
    endfunction

    function void note_input(logic signed [23:0] x);
        pending.push_back(clip_sample(x));
    endfunction

    function void check_output(logic signed [23:0] y);
        logic signed [23:0] want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected output beat: %0d", y);
            return;
        end
        want = pending.pop_front();
        if (y !== want) begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected %0d, actual %0d", want, y);
        end
    endfunction
endclass

module tb_knee_soft_clipper;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [ksc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ksc_pkg::LEVEL_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [ksc_pkg::SAMPLE_W-1:0] sample_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ksc_pkg::SAMPLE_W-1:0] sample_out;

    clip_scoreboard sb = new();
    bit idle_on = 1'b1;
    int hold_request = 0;
    int cycle_count = 0;

    knee_soft_clipper DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int idle_left;
        idle_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_output(sample_out);
            @(negedge clk);
            if (hold_request > 0) begin
                hold_request--;
                out_ready = 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                out_ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 13);
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_sample(logic signed [23:0] x);
        @(negedge clk);
        in_valid = 1'b1;
        sample_in = x;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(x);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(ksc_pkg::cfg_reg_t idx, logic [22:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic apply_setting(logic [22:0] thr, logic [22:0] knee, logic [22:0] asym);
        drain_pipeline();
        write_reg(ksc_pkg::REG_THRESHOLD, thr);
        write_reg(ksc_pkg::REG_KNEE, knee);
        write_reg(ksc_pkg::REG_ASYM, asym);
    endtask

    function automatic logic signed [23:0] pick_sample();
        longint base, v;
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed(24'($urandom_range(0, 4095))) - 2048);
            default: begin
                base = ($urandom_range(0, 1)) ? sb.thr + sb.knee : sb.thr - sb.knee;
                v = base + $signed(32'($urandom_range(0, 2 * sb.knee + 64))) - sb.knee - 32;
                if ($urandom_range(0, 1))
                    v = -v;
                if (v > 8388607)
                    v = 8388607;
                if (v < -8388608)
                    v = -8388608;
                return 24'(v);
            end
        endcase
    endfunction

    task automatic edge_samples();
        longint lv[6];
        lv[0] = sb.thr;
        lv[1] = sb.thr - sb.knee;
        lv[2] = sb.thr + sb.knee;
        lv[3] = 1;
        lv[4] = 8388607;
        lv[5] = sb.thr + sb.knee - 1;
        send_sample(24'sd0);
        send_sample(24'sh800000);
        foreach (lv[i]) begin
            send_sample(24'(lv[i]));
            send_sample(24'(-lv[i]));
        end
    endtask

    task automatic random_run(int count);
        repeat (count) send_sample(pick_sample());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        edge_samples();
        random_run(150);

        apply_setting(23'd1048576, 23'd0, 23'd0);
        edge_samples();
        random_run(100);

        apply_setting(23'd0, 23'd0, 23'd1048576);
        random_run(40);

        apply_setting(23'd8388607, 23'd8388607, 23'h1FFFFF);
        edge_samples();
        random_run(100);

        apply_setting(23'd100000, 23'd600000, 23'd1048576);
        edge_samples();
        random_run(120);

        apply_setting(23'd2097152, 23'd1, 23'd524288);
        edge_samples();
        random_run(80);

        apply_setting(23'd1048576, 23'd262144, 23'd300000);
        hold_request = 300;
        idle_on = 1'b0;
        random_run(150);
        idle_on = 1'b1;
        drain_pipeline();
        random_run(50);

        repeat (6) begin
            apply_setting(23'($urandom_range(0, 8388607)), 23'($urandom_range(1, 3000000)),
                          23'($urandom_range(0, 2097151)));
            random_run(100);
        end

        apply_setting(23'($urandom_range(500000, 4000000)), 23'($urandom_range(1, 1000000)),
                      23'($urandom_range(0, 1048576)));
        idle_on = 1'b0;
        random_run(120);

        drain_pipeline();
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/ksc_pkg.sv
rtl/core/ksc_div.sv
rtl/core/ksc_tanh.sv
rtl/core/knee_soft_clipper.sv
rtl/core/ksc_assert.sv
tb/tb_knee_soft_clipper.sv
